@@ sv/normal_map_vertex_displace_core_defines.svh @@
// Assertion macros shared by the displacement core.
`ifndef NORMAL_MAP_VERTEX_DISPLACE_CORE_DEFINES_SVH
`define NORMAL_MAP_VERTEX_DISPLACE_CORE_DEFINES_SVH

// Same-cycle implication, clocked by aclk and quiet while aresetn is low.
`define NMVD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked by aclk and quiet while aresetn is low.
`define NMVD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/nmvd_pkg.sv @@
// Shared types and constants of the normal map vertex displacement core.
`timescale 1ns / 1ps

package nmvd_pkg;

    // Default sizing of the texture sampler and the blue store.
    localparam int DEF_MAX_DIM   = 256;
    localparam int DEF_TEX_DEPTH = 65536;

    // Beat kinds carried on s_tuser.
    typedef enum logic {
        OP_TEXEL_WRITE = 1'b0,
        OP_VERTEX      = 1'b1
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH       = 2'd0,
        CFG_IMAGE_HEIGHT      = 2'd1,
        CFG_FLIP_V            = 2'd2,
        CFG_DISPLACE_STRENGTH = 2'd3
    } cfg_idx_t;

    // Exact unsigned division by 255 for 32-bit dividends: (a * MAGIC) >> 39.
    localparam logic [31:0] DIV255_MAGIC = 32'h8080_8081;
    localparam int          DIV255_SHIFT = 39;

    // Fraction bits of the Q1.14 normal components.
    localparam int NORM_FRAC_BITS = 14;

endpackage

@@ sv/nmvd_tex_ram.sv @@
// Single-port blue channel store with registered read data.
`timescale 1ns / 1ps

module nmvd_tex_ram #(
    parameter int DEPTH = nmvd_pkg::DEF_TEX_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Read data only moves when the pipeline stage behind the store loads.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/normal_map_vertex_displace_core.sv @@
// Top level of the normal map vertex displacement core.
//
//  Channel  Direction  Handshake             Contents
//  s_       in         s_tvalid / s_tready   tuser: kind; tdata: texel or vertex fields
//  m_       out        m_tvalid / m_tready   tdata: displaced position x, y, z
//  cfg_     in         cfg_wr_en             register index and write data
//
// Every stage holds one item, so while m_ does not stall one beat can enter and one result
// leave every cycle. A vertex beat runs through stages 0 to 13 onto m_; texel writes hit the
// store between stages 5 and 6, in stream order with vertex reads, and return nothing.
// Reset clears the configuration registers and the stage valid bits; the blue store has
// no clearing pass; the user must write every entry before it is sampled, which the core does not enforce.
// A stall on m_ only holds the stages that are full: s_tready falls once all 14 are.
`timescale 1ns / 1ps
`include "normal_map_vertex_displace_core_defines.svh"

module normal_map_vertex_displace_core #(
    parameter int MAX_DIM   = nmvd_pkg::DEF_MAX_DIM,
    parameter int TEX_DEPTH = nmvd_pkg::DEF_TEX_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_tvalid,
    output logic          s_tready,
    // Bits from the lowest up: texel_addr[15:0], texel_blue[23:16], tex_u[47:24],
    // tex_v[71:48], pos_x[103:72], pos_y[135:104], pos_z[167:136],
    // norm_x[183:168], norm_y[199:184], norm_z[215:200].
    input  logic [215:0]  s_tdata,
    // Bits from the lowest up: operation[0].
    input  logic [0:0]    s_tuser,

    output logic          m_tvalid,
    input  logic          m_tready,
    // Bits from the lowest up: new_x[31:0], new_y[63:32], new_z[95:64].
    output logic [95:0]   m_tdata,

    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_addr,
    input  logic [23:0]   cfg_wr_data
);

    // Widths that follow from the sampler size and the store depth.
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LIN_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int AW     = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;
    localparam int DEP_W  = $clog2(TEX_DEPTH + 1);
    localparam int RW     = ((AW > LIN_W) ? AW : LIN_W) + 1;
    localparam int UVP_W  = 17 + DIM_W;
    localparam int LP_W   = IDX_W + DIM_W;

    // The linear texel index is reduced modulo TEX_DEPTH with a floor reciprocal.
    // With REC_K equal to the index width the quotient estimate is low by at most
    // one, so a single compare and subtract finishes the remainder.
    localparam int              REC_K = LIN_W;
    localparam int              REC_W = REC_K + 1;
    localparam longint unsigned REC   = (64'd1 << REC_K) / TEX_DEPTH;
    localparam int              QP_W  = LIN_W + REC_W;
    localparam int              QD_W  = LIN_W + DEP_W;

    // Stage map: 0 input, 1 texel coordinates, 2 linear index, 3 quotient estimate,
    // 4 raw remainder, 5 store address, 6 store read, 7 strength product,
    // 8 magnitude, 9 reciprocal product, 10 displacement, 11 normal products,
    // 12 rounded offsets, 13 saturated result.
    localparam int NST     = 14;
    localparam int MEM_ST  = 5;
    localparam int DROP_ST = MEM_ST + 2;

    localparam logic signed [41:0] NORM_ROUND = 42'((1 << nmvd_pkg::NORM_FRAC_BITS) - 1);
    localparam int                 OFF_LO     = nmvd_pkg::NORM_FRAC_BITS;

    typedef struct packed {
        nmvd_pkg::op_t          op;
        logic                   wr_ok;
        logic [AW-1:0]          waddr;
        logic [7:0]             blue_w;
        logic [15:0]            fu;
        logic [16:0]            fv;
        logic [2:0][31:0]       pos;
        logic [2:0][15:0]       norm;
        logic [IDX_W-1:0]       px;
        logic [IDX_W-1:0]       py;
        logic [LIN_W-1:0]       lin;
        logic [LIN_W-1:0]       qe;
        logic [RW-1:0]          rem;
        logic [AW-1:0]          addr;
        logic signed [32:0]     prod;
        logic                   sgn;
        logic [31:0]            mag;
        logic [63:0]            mprod;
        logic signed [25:0]     disp;
        logic [2:0][41:0]       offp;
        logic [2:0][27:0]       off;
        logic [2:0][31:0]       res;
    } pipe_t;

    // Configuration registers.
    logic [8:0]          cfg_width_reg;
    logic [8:0]          cfg_height_reg;
    logic                cfg_flip_reg;
    logic signed [23:0]  cfg_strength_reg;

    logic [DIM_W-1:0]    eff_w;
    logic [DIM_W-1:0]    eff_h;
    logic [DIM_W-1:0]    wm1;
    logic [DIM_W-1:0]    hm1;

    // Pipeline.
    pipe_t               st_reg  [NST];
    pipe_t               st_next [NST];
    logic [NST-1:0]      v_reg;
    logic [NST-1:0]      v_next;
    logic [NST-1:0]      ld;

    // Blue store port.
    logic                ram_en;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [7:0]          ram_wdata;
    logic [7:0]          ram_rdata;

    // ------------------------------------------------------------------
    // Configuration writes. The register index is decoded in full, so every
    // code selects one of the four registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg    <= 9'd1;
            cfg_height_reg   <= 9'd1;
            cfg_flip_reg     <= 1'b0;
            cfg_strength_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (nmvd_pkg::cfg_idx_t'(cfg_addr))
                nmvd_pkg::CFG_IMAGE_WIDTH:       cfg_width_reg    <= cfg_wr_data[8:0];
                nmvd_pkg::CFG_IMAGE_HEIGHT:      cfg_height_reg   <= cfg_wr_data[8:0];
                nmvd_pkg::CFG_FLIP_V:            cfg_flip_reg     <= cfg_wr_data[0];
                nmvd_pkg::CFG_DISPLACE_STRENGTH: cfg_strength_reg <= $signed(cfg_wr_data);
            endcase
        end
    end

    // A dimension of zero samples as one texel, one above MAX_DIM as MAX_DIM.
    always_comb begin
        if (cfg_width_reg == 9'd0) begin
            eff_w = DIM_W'(1);
        end else if (32'(cfg_width_reg) > 32'(MAX_DIM)) begin
            eff_w = DIM_W'(MAX_DIM);
        end else begin
            eff_w = DIM_W'(cfg_width_reg);
        end
        if (cfg_height_reg == 9'd0) begin
            eff_h = DIM_W'(1);
        end else if (32'(cfg_height_reg) > 32'(MAX_DIM)) begin
            eff_h = DIM_W'(MAX_DIM);
        end else begin
            eff_h = DIM_W'(cfg_height_reg);
        end
        wm1 = eff_w - DIM_W'(1);
        hm1 = eff_h - DIM_W'(1);
    end

    // ------------------------------------------------------------------
    // Stage loads. A stage takes a new beat when it is empty or when the stage
    // behind it takes its current one, so bubbles collapse under a stall.
    // ------------------------------------------------------------------
    always_comb begin
        ld[NST-1] = !v_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end

    // Texel writes are done once they pass the store, so their valid bit drops there.
    always_comb begin
        v_next[0] = s_tvalid;
        for (int i = 1; i < NST; i++) begin
            v_next[i] = v_reg[i-1] &&
                        ((i != DROP_ST) || (st_reg[i-1].op == nmvd_pkg::OP_VERTEX));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (ld[i]) begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NST; i++) begin
            if (ld[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage logic. Each stage copies the stage ahead of it and fills in the
    // fields it is responsible for.
    // ------------------------------------------------------------------
    always_comb begin
        logic [UVP_W-1:0]    u_prod;
        logic [UVP_W-1:0]    v_prod;
        logic [LP_W-1:0]     row_prod;
        logic [QP_W-1:0]     q_prod;
        logic [QD_W-1:0]     qd_prod;
        logic [RW-1:0]       rem;
        logic [7:0]          inv_blue;
        logic signed [33:0]  dbl;
        logic signed [41:0]  rnd;
        logic signed [32:0]  sum;

        // Stage 0: register the beat, wrap V and apply the flip.
        st_next[0]        = '0;
        st_next[0].op     = nmvd_pkg::op_t'(s_tuser[0]);
        st_next[0].waddr  = AW'(s_tdata[15:0]);
        st_next[0].wr_ok  = 32'(s_tdata[15:0]) < 32'(TEX_DEPTH);
        st_next[0].blue_w = s_tdata[23:16];
        st_next[0].fu     = s_tdata[39:24];
        // With the flip a fraction of zero becomes 1.0, which selects the last row.
        st_next[0].fv     = cfg_flip_reg ? (17'h1_0000 - {1'b0, s_tdata[63:48]})
                                         : {1'b0, s_tdata[63:48]};
        st_next[0].pos    = s_tdata[167:72];
        st_next[0].norm   = s_tdata[215:168];

        for (int i = 1; i < NST; i++) begin
            st_next[i] = st_reg[i-1];
        end

        // Stage 1: nearest texel, trunc(frac * (dim - 1)); never above dim - 1.
        u_prod = UVP_W'({1'b0, st_reg[0].fu}) * UVP_W'(wm1);
        v_prod = UVP_W'(st_reg[0].fv) * UVP_W'(hm1);
        st_next[1].px = u_prod[16 +: IDX_W];
        st_next[1].py = v_prod[16 +: IDX_W];

        // Stage 2: linear index row * width + column.
        row_prod = LP_W'(st_reg[1].py) * LP_W'(eff_w);
        st_next[2].lin = LIN_W'(row_prod) + LIN_W'(st_reg[1].px);

        // Stage 3: quotient estimate of the index over the store depth.
        q_prod = QP_W'(st_reg[2].lin) * QP_W'(REC);
        st_next[3].qe = q_prod[REC_K +: LIN_W];

        // Stage 4: remainder, below twice the depth.
        qd_prod = QD_W'(st_reg[3].qe) * QD_W'(TEX_DEPTH);
        st_next[4].rem = RW'(st_reg[3].lin) - RW'(qd_prod);

        // Stage 5: final store address; texel writes keep their own address.
        rem = st_reg[4].rem;
        if (rem >= RW'(TEX_DEPTH)) begin
            rem = rem - RW'(TEX_DEPTH);
        end
        st_next[5].addr = (st_reg[4].op == nmvd_pkg::OP_VERTEX) ? AW'(rem)
                                                                 : st_reg[4].waddr;

        // Stage 6 holds the beat while the store read completes.

        // Stage 7: strength * (255 - blue); the factor of two is folded in below.
        inv_blue = 8'd255 - ram_rdata;
        st_next[7].prod = 33'(cfg_strength_reg) * 33'($signed({1'b0, inv_blue}));

        // Stage 8: sign and magnitude of 2 * strength * (255 - blue).
        dbl = {st_reg[7].prod, 1'b0};
        st_next[8].sgn = st_reg[7].prod[32];
        st_next[8].mag = st_reg[7].prod[32] ? 32'(-dbl) : 32'(dbl);

        // Stage 9: reciprocal product for the division by 255.
        st_next[9].mprod = 64'(st_reg[8].mag) * 64'(nmvd_pkg::DIV255_MAGIC);

        // Stage 10: quotient with the sign restored, so it truncates toward zero.
        st_next[10].disp = st_reg[9].sgn
            ? -26'(st_reg[9].mprod[nmvd_pkg::DIV255_SHIFT +: 25])
            :  26'(st_reg[9].mprod[nmvd_pkg::DIV255_SHIFT +: 25]);

        // Stages 11 to 13 work on the three axes side by side.
        for (int j = 0; j < 3; j++) begin
            st_next[11].offp[j] = 42'($signed(st_reg[10].disp)) *
                                  42'($signed(st_reg[10].norm[j]));

            // Divide by 2^14 toward zero: bias negative products before the shift.
            rnd = $signed(st_reg[11].offp[j]) +
                  (st_reg[11].offp[j][41] ? NORM_ROUND : 42'sd0);
            st_next[12].off[j] = rnd[OFF_LO +: 28];

            sum = 33'($signed(st_reg[12].pos[j])) + 33'($signed(st_reg[12].off[j]));
            if (sum[32] != sum[31]) begin
                st_next[13].res[j] = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                st_next[13].res[j] = sum[31:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Blue store. It sits between stage 5 and stage 6 and moves with stage 6,
    // so reads and writes reach it in the order the beats arrived.
    // ------------------------------------------------------------------
    assign ram_en    = ld[MEM_ST+1];
    assign ram_we    = ld[MEM_ST+1] && v_reg[MEM_ST] && st_reg[MEM_ST].wr_ok &&
                       (st_reg[MEM_ST].op == nmvd_pkg::OP_TEXEL_WRITE);
    assign ram_addr  = st_reg[MEM_ST].addr;
    assign ram_wdata = st_reg[MEM_ST].blue_w;

    nmvd_tex_ram #(
        .DEPTH (TEX_DEPTH),
        .AW    (AW)
    ) u_tex_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Ports.
    // ------------------------------------------------------------------
    assign s_tready = ld[0];
    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = st_reg[NST-1].res;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `NMVD_ASSERT_IMP(a_blocked_only_when_full, !s_tready, &v_reg, "input blocked with a free stage")
    `NMVD_ASSERT_IMP(a_result_is_vertex, m_tvalid, st_reg[NST-1].op == nmvd_pkg::OP_VERTEX, "texel write reached the output")
    `NMVD_ASSERT_NXT(a_write_moves_on, ram_we, v_reg[MEM_ST+1] && (st_reg[MEM_ST+1].op == nmvd_pkg::OP_TEXEL_WRITE), "store write out of step with its stage")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the normal map vertex displacement core.
`timescale 1ns / 1ps

module testbench;

    // The run is bounded by a generous cycle limit. About 900 beats go in, counting the
    // texel writes placed ahead of vertices. Even with 74% stalls on one side, the limit
    // is far beyond any correct run.
    localparam int TIMEOUT_CYCLES = 200000;
    // This margin covers the vertex path and the texel writes still in flight, both
    // before a register write and at the end of the run.
    localparam int DRAIN_CYCLES   = 24;
    localparam int RANDOM_BEATS   = 110;
    localparam int PHASES         = 6;
    localparam int STORE_DEPTH    = nmvd_pkg::DEF_TEX_DEPTH;
    localparam longint POS_MAX    = 64'sd2147483647;
    localparam longint POS_MIN    = -64'sd2147483648;

    // One input beat, either a texel write or a vertex.
    typedef struct {
        nmvd_pkg::op_t      op;
        logic [15:0]        addr;
        logic [7:0]         blue;
        logic signed [23:0] u;
        logic signed [23:0] v;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } mesh_beat_t;

    // One displaced position, as it appears on m_tdata.
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } position_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    // Bits from the lowest up: texel_addr, texel_blue, tex_u, tex_v, pos_x, pos_y, pos_z,
    // norm_x, norm_y, norm_z.
    logic [215:0]  s_tdata;
    // Bits from the lowest up: operation.
    logic [0:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    // Bits from the lowest up: new_x, new_y, new_z.
    logic [95:0]   m_tdata;
    logic          cfg_wr_en;
    logic [1:0]    cfg_addr;
    logic [23:0]   cfg_wr_data;

    normal_map_vertex_displace_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // The testbench keeps its own copy of the blue store and of the registers.
    // The copies are updated at the same clock edges where the core takes the beats.
    logic [7:0]         blue_shadow [STORE_DEPTH];
    logic [8:0]         width_reg    = 9'd1;
    logic [8:0]         height_reg   = 9'd1;
    logic               flip_reg     = 1'b0;
    logic signed [23:0] strength_reg = '0;

    // The stimulus generator records every address that some queued beat writes.
    // No vertex is ever queued that would sample a texel the core has not received.
    bit                 texel_planned [STORE_DEPTH];

    mesh_beat_t  pending_beats[$];
    position_t   expected_positions[$];
    mesh_beat_t  beat_on_bus;
    bit          beat_taken;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          cycle_count = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A width or height of zero samples as one texel. Anything past the maximum
    // dimension samples as the maximum.
    function automatic int unsigned clamp_dim(logic [8:0] d);
        if (d == 9'd0) return 1;
        if (32'(d) > nmvd_pkg::DEF_MAX_DIM) return nmvd_pkg::DEF_MAX_DIM;
        return 32'(d);
    endfunction

    // Nearest texel along one axis: trunc(frac * (dim - 1)), where frac is Q0.16 and can
    // reach 1.0 after a V flip.
    function automatic int unsigned nearest_index(int unsigned frac, int unsigned dim);
        longint unsigned f, d, idx;
        f = 64'(frac);
        d = 64'(dim - 1);
        idx = (f * d) >> 16;
        if (idx > d) idx = d;
        return 32'(idx);
    endfunction

    // Linear store address that a vertex with this UV samples under the current registers.
    function automatic logic [15:0] texel_address(logic [23:0] u, logic [23:0] v);
        int unsigned w, h, fu, fv, col, row;
        w  = clamp_dim(width_reg);
        h  = clamp_dim(height_reg);
        fu = 32'(u[15:0]);
        fv = 32'(v[15:0]);
        // With the flip, a V fraction of zero becomes exactly 1.0 and lands on the last row.
        if (flip_reg) fv = 65536 - fv;
        col = nearest_index(fu, w);
        row = nearest_index(fv, h);
        return 16'(row * w + col);
    endfunction

    // Push one coordinate along its normal component, then saturate to 32 bits.
    function automatic logic signed [31:0] shift_axis(logic signed [31:0] pos,
                                                      logic signed [15:0] nrm,
                                                      longint disp);
        longint sum;
        sum = longint'(pos) + (disp * longint'(nrm)) / 16384;
        if (sum > POS_MAX) sum = POS_MAX;
        if (sum < POS_MIN) sum = POS_MIN;
        return sum[31:0];
    endfunction

    function automatic position_t displace_vertex(mesh_beat_t b);
        position_t r;
        longint    blue, disp;
        blue = 64'(blue_shadow[texel_address(b.u, b.v)]);
        // A dark blue channel pushes hardest. The division truncates toward zero for
        // negative strengths too.
        disp = (longint'(strength_reg) * 2 * (255 - blue)) / 255;
        r.x = shift_axis(b.px, b.nx, disp);
        r.y = shift_axis(b.py, b.ny, disp);
        r.z = shift_axis(b.pz, b.nz, disp);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH %s at result %0d: got %h, expected %h",
                 what, results_seen, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: a new beat is presented at the falling edge once the previous one
    // was taken. Between beats, the input channel idles at random.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || beat_taken)) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                beat_on_bus = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= beat_on_bus.op;
                s_tdata  <= {beat_on_bus.nz, beat_on_bus.ny, beat_on_bus.nx,
                             beat_on_bus.pz, beat_on_bus.py, beat_on_bus.px,
                             beat_on_bus.v, beat_on_bus.u, beat_on_bus.blue,
                             beat_on_bus.addr};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        beat_taken = 1'b0;
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge it applies register writes and accepted beats to the
    // copy of the state, and checks every accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        position_t got, want;
        if (!aresetn) begin
            width_reg    = 9'd1;
            height_reg   = 9'd1;
            flip_reg     = 1'b0;
            strength_reg = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    nmvd_pkg::CFG_IMAGE_WIDTH:       width_reg    = cfg_wr_data[8:0];
                    nmvd_pkg::CFG_IMAGE_HEIGHT:      height_reg   = cfg_wr_data[8:0];
                    nmvd_pkg::CFG_FLIP_V:            flip_reg     = cfg_wr_data[0];
                    nmvd_pkg::CFG_DISPLACE_STRENGTH: strength_reg = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.x = m_tdata[31:0];
                got.y = m_tdata[63:32];
                got.z = m_tdata[95:64];
                if (expected_positions.size() == 0) begin
                    report_mismatch("result with nothing expected, new_x", got.x, '0);
                end else begin
                    want = expected_positions.pop_front();
                    if (got.x !== want.x) report_mismatch("new_x", got.x, want.x);
                    if (got.y !== want.y) report_mismatch("new_y", got.y, want.y);
                    if (got.z !== want.z) report_mismatch("new_z", got.z, want.z);
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                beat_taken = 1'b1;
                if (beat_on_bus.op == nmvd_pkg::OP_TEXEL_WRITE)
                    blue_shadow[beat_on_bus.addr] = beat_on_bus.blue;
                else
                    expected_positions.push_back(displace_vertex(beat_on_bus));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Every field is random. Callers overwrite the fields that matter for the case at hand.
    function automatic mesh_beat_t random_beat(nmvd_pkg::op_t op);
        mesh_beat_t b;
        b.op   = op;
        b.addr = 16'($urandom);
        b.blue = 8'($urandom);
        b.u    = 24'($urandom);
        b.v    = 24'($urandom);
        b.px   = $urandom;
        b.py   = $urandom;
        b.pz   = $urandom;
        b.nx   = 16'($urandom);
        b.ny   = 16'($urandom);
        b.nz   = 16'($urandom);
        return b;
    endfunction

    task automatic queue_texel(logic [15:0] addr, logic [7:0] blue);
        mesh_beat_t b;
        b = random_beat(nmvd_pkg::OP_TEXEL_WRITE);
        b.addr = addr;
        b.blue = blue;
        texel_planned[addr] = 1'b1;
        pending_beats.push_back(b);
    endtask

    // If the sampled texel has not been written yet, a write with a random blue goes in
    // first. This keeps every read inside what the core guarantees.
    task automatic queue_vertex(mesh_beat_t b);
        logic [15:0] addr;
        addr = texel_address(b.u, b.v);
        if (!texel_planned[addr]) queue_texel(addr, 8'($urandom));
        b.op = nmvd_pkg::OP_VERTEX;
        pending_beats.push_back(b);
    endtask

    // Registers change only after the last result is out and in-flight texel writes
    // have landed.
    task automatic wait_for_drain();
        while (pending_beats.size() != 0 || s_tvalid || expected_positions.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(nmvd_pkg::cfg_idx_t idx, logic [23:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Runs with a 4 x 3 texture, V flipped and the largest positive strength.
    task automatic queue_directed();
        mesh_beat_t b, rewrite;
        queue_texel(16'h0000, 8'h00);
        queue_texel(16'hFFFF, 8'hFF);
        queue_texel(16'd8, 8'h00);
        queue_texel(16'd10, 8'h00);
        // A V fraction of zero flips to 1.0 and samples the last row (address 8).
        rewrite = random_beat(nmvd_pkg::OP_VERTEX);
        rewrite.u  = '0;
        rewrite.v  = '0;
        rewrite.nx = 16'sd16384;
        rewrite.ny = '0;
        rewrite.nz = -16'sd16384;
        queue_vertex(rewrite);
        // Highest UV corner with the full normal and full position: saturates high.
        b = random_beat(nmvd_pkg::OP_VERTEX);
        b.u  = 24'h7FFFFF;
        b.v  = 24'h800000;
        b.px = 32'h7FFFFFFF;
        b.py = 32'h7FFFFFFF;
        b.pz = 32'h7FFFFFFF;
        b.nx = 16'h7FFF;
        b.ny = 16'h7FFF;
        b.nz = 16'h7FFF;
        queue_vertex(b);
        // Most negative normal at the most negative position: saturates low.
        b = random_beat(nmvd_pkg::OP_VERTEX);
        b.u  = 24'h800000;
        b.v  = 24'h7FFFFF;
        b.px = 32'h80000000;
        b.py = 32'h80000000;
        b.pz = 32'h80000000;
        b.nx = 16'h8000;
        b.ny = 16'h8000;
        b.nz = 16'h8000;
        queue_vertex(b);
        // A texel rewrite followed right away by a read of the same texel.
        queue_texel(16'd8, 8'h80);
        queue_vertex(rewrite);
        // Full blue gives zero displacement.
        queue_texel(16'h0000, 8'hFF);
        b = random_beat(nmvd_pkg::OP_VERTEX);
        b.u = 24'h010000;
        b.v = 24'h00FFFF;
        queue_vertex(b);
        // A zero normal leaves the position unchanged.
        b = random_beat(nmvd_pkg::OP_VERTEX);
        b.nx = '0;
        b.ny = '0;
        b.nz = '0;
        queue_vertex(b);
    endtask

    task automatic queue_random(int unsigned count);
        mesh_beat_t  b;
        int unsigned span;
        span = clamp_dim(width_reg) * clamp_dim(height_reg);
        repeat (count) begin
            if ($urandom_range(99) < 30) begin
                // Most writes hit the sampled area, so later vertices see fresh values.
                b = random_beat(nmvd_pkg::OP_TEXEL_WRITE);
                if ($urandom_range(3) != 0) b.addr = 16'($urandom_range(span - 1));
                queue_texel(b.addr, b.blue);
            end else begin
                b = random_beat(nmvd_pkg::OP_VERTEX);
                case ($urandom_range(7))
                    0: b.v[15:0] = '0;
                    1: b.u[15:0] = 16'hFFFF;
                    2: begin
                        b.px = 32'h7FFFFFFF - $urandom_range(32'h01FFFFFF);
                        b.py = 32'h7FFFFFFF - $urandom_range(32'h01FFFFFF);
                        b.pz = 32'h7FFFFFFF - $urandom_range(32'h01FFFFFF);
                    end
                    3: begin
                        b.px = 32'h80000000 + $urandom_range(32'h01FFFFFF);
                        b.py = 32'h80000000 + $urandom_range(32'h01FFFFFF);
                        b.pz = 32'h80000000 + $urandom_range(32'h01FFFFFF);
                    end
                    4: begin
                        b.nx = 16'h7FFF;
                        b.ny = 16'h8000;
                        b.nz = 16'sd16384;
                    end
                    default: ;
                endcase
                queue_vertex(b);
            end
        end
    endtask

    initial begin
        int unsigned phase;
        logic [8:0]  w, h;
        logic        flip;
        logic [23:0] strength;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = nmvd_pkg::OP_TEXEL_WRITE;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = nmvd_pkg::CFG_IMAGE_WIDTH;
        cfg_wr_data = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            wait_for_drain();
            // The sender idles lightly while the receiver stalls heavily, then the roles
            // swap, and the last phases run at full rate.
            send_idle_pct = (phase < 2) ? 12 : (phase < 4) ? 74 : 0;
            recv_idle_pct = (phase < 2) ? 74 : (phase < 4) ? 12 : 0;
            // The phases cover both dimension extremes, out-of-range dimensions on both
            // axes, both flip settings and both strength extremes.
            case (phase)
                0: begin w = 9'd4;   h = 9'd3;   flip = 1'b1; strength = 24'h7FFFFF; end
                1: begin w = 9'd256; h = 9'd256; flip = 1'b0; strength = 24'h800000; end
                2: begin w = 9'd0;   h = 9'd511; flip = 1'b1; strength = 24'($urandom); end
                3: begin w = 9'd1;   h = 9'd1;   flip = 1'b0; strength = 24'h010000; end
                4: begin w = 9'd511; h = 9'd0;   flip = 1'b1; strength = 24'hFFFFFF; end
                default: begin
                    w        = 9'($urandom_range(1, nmvd_pkg::DEF_MAX_DIM));
                    h        = 9'($urandom_range(1, nmvd_pkg::DEF_MAX_DIM));
                    flip     = 1'($urandom_range(1));
                    strength = 24'($urandom);
                end
            endcase
            write_register(nmvd_pkg::CFG_IMAGE_WIDTH, {15'd0, w});
            write_register(nmvd_pkg::CFG_IMAGE_HEIGHT, {15'd0, h});
            write_register(nmvd_pkg::CFG_FLIP_V, {23'd0, flip});
            write_register(nmvd_pkg::CFG_DISPLACE_STRENGTH, strength);
            if (phase == 0) queue_directed();
            queue_random(RANDOM_BEATS);
        end

        wait_for_drain();
        if (mismatch_count == 0 && expected_positions.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/nmvd_pkg.sv
sv/nmvd_tex_ram.sv
sv/normal_map_vertex_displace_core.sv
tb/testbench.sv
